// ===== rtl/slw_pkg.sv =====
package slw_pkg;

    // table geometry
    localparam int SPRITE_ENTRIES = 80;
    localparam int BYTES_PER_SPRITE = 8;
    localparam int ROW_W = 7;
    localparam int LANE_W = 3;
    localparam int ROW_BITS = BYTES_PER_SPRITE * 8;

    // request kinds on the input channel
    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_RESTART = 2'd1,
        MODE_STEP    = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    // program steps
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_READ   = 3'd1,
        ST_DECODE = 3'd2,
        ST_EMIT   = 3'd3,
        ST_FINISH = 3'd4,
        ST_CLEAR  = 3'd5
    } t_step;

    // jump conditions
    typedef enum logic [1:0] {
        C_DISPATCH = 2'd0,
        C_GO       = 2'd1,
        C_EMIT     = 2'd2,
        C_CLEAR    = 2'd3
    } t_cond;

    // one control word of the program
    typedef struct packed {
        t_cond cond;
        t_step target;
        logic  rd;
        logic  dec;
        logic  emit;
        logic  fin;
        logic  clr;
    } t_uword;

    // control from the sequencer to the datapath and store
    typedef struct packed {
        logic clr;
        logic wr;
        logic rd;
        logic dec;
        logic emit;
        logic fin;
        logic restart;
    } t_ctrl;

    // status back to the sequencer
    typedef struct packed {
        logic walk_done;
        logic last_loaded;
        logic clr_last;
    } t_status;

    // program rom
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        begin
            case (s)
                ST_IDLE: begin
                    w = '{cond: C_DISPATCH, target: ST_IDLE, rd: 1'b0, dec: 1'b0,
                          emit: 1'b0, fin: 1'b0, clr: 1'b0};
                end
                ST_READ: begin
                    w = '{cond: C_GO, target: ST_DECODE, rd: 1'b1, dec: 1'b0,
                          emit: 1'b0, fin: 1'b0, clr: 1'b0};
                end
                ST_DECODE: begin
                    w = '{cond: C_GO, target: ST_EMIT, rd: 1'b0, dec: 1'b1,
                          emit: 1'b0, fin: 1'b0, clr: 1'b0};
                end
                ST_EMIT: begin
                    w = '{cond: C_EMIT, target: ST_FINISH, rd: 1'b0, dec: 1'b0,
                          emit: 1'b1, fin: 1'b0, clr: 1'b0};
                end
                ST_FINISH: begin
                    w = '{cond: C_GO, target: ST_IDLE, rd: 1'b0, dec: 1'b0,
                          emit: 1'b0, fin: 1'b1, clr: 1'b0};
                end
                ST_CLEAR: begin
                    w = '{cond: C_CLEAR, target: ST_IDLE, rd: 1'b0, dec: 1'b0,
                          emit: 1'b0, fin: 1'b0, clr: 1'b1};
                end
                default: begin
                    w = '{cond: C_GO, target: ST_IDLE, rd: 1'b0, dec: 1'b0,
                          emit: 1'b0, fin: 1'b0, clr: 1'b0};
                end
            endcase
            return w;
        end
    endfunction

endpackage

// ===== rtl/slw_store.sv =====
module slw_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  slw_pkg::t_ctrl                 i_ctrl,
    input  logic [slw_pkg::ROW_W-1:0]      i_wr_row,
    input  logic [slw_pkg::LANE_W-1:0]     i_wr_lane,
    input  logic [7:0]                     i_wr_byte,
    input  logic [slw_pkg::ROW_W-1:0]      i_rd_row,
    output logic [slw_pkg::ROW_BITS-1:0]   o_rd_data,
    output logic                           o_clr_last
);
    import slw_pkg::*;

    logic [ROW_BITS-1:0] r_mem [0:SPRITE_ENTRIES-1];
    logic [ROW_BITS-1:0] r_rd_data;
    logic [ROW_W-1:0]    r_clr_row;
    logic [ROW_W-1:0]    n_clr_row;

    assign o_clr_last = (r_clr_row == ROW_W'(SPRITE_ENTRIES - 1));
    assign o_rd_data  = r_rd_data;

    // clearing sweep row counter
    always_comb begin
        n_clr_row = r_clr_row;
        if (i_ctrl.clr && !o_clr_last) begin
            n_clr_row = r_clr_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
        end else begin
            r_clr_row <= n_clr_row;
        end
    end

    // single write port: clearing sweep or byte write
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_mem[r_clr_row] <= '0;
        end else if (i_ctrl.wr) begin
            r_mem[i_wr_row][i_wr_lane*8 +: 8] <= i_wr_byte;
        end
    end

    // registered row read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

endmodule

// ===== rtl/slw_seq.sv =====
module slw_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [1:0]                 i_mode,
    input  logic [slw_pkg::ROW_W-1:0]  i_wr_row,
    input  slw_pkg::t_status           i_status,
    output logic                       o_stall,
    output slw_pkg::t_ctrl             o_ctrl
);
    import slw_pkg::*;

    t_step  r_pc;
    t_step  n_pc;
    t_uword w;
    logic   accept;
    logic   in_range;

    assign in_range = ({1'b0, i_wr_row} < (ROW_W + 1)'(SPRITE_ENTRIES));

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_CLEAR;
        end else begin
            r_pc <= n_pc;
        end
    end

    // control word decode and jumps
    always_comb begin
        w       = ucode(r_pc);
        o_stall = (w.cond != C_DISPATCH);
        accept  = (w.cond == C_DISPATCH) && i_valid;
        o_ctrl  = '0;
        o_ctrl.clr  = w.clr;
        o_ctrl.rd   = w.rd;
        o_ctrl.dec  = w.dec;
        o_ctrl.emit = w.emit;
        o_ctrl.fin  = w.fin;
        o_ctrl.wr      = accept && (i_mode == MODE_WRITE) && in_range;
        o_ctrl.restart = accept && (i_mode == MODE_RESTART);
        n_pc = r_pc;
        case (w.cond)
            C_DISPATCH: begin
                if (accept && (i_mode == MODE_STEP) && !i_status.walk_done) begin
                    n_pc = ST_READ;
                end
            end
            C_GO: begin
                n_pc = w.target;
            end
            C_EMIT: begin
                if (i_status.last_loaded) begin
                    n_pc = w.target;
                end
            end
            C_CLEAR: begin
                if (i_status.clr_last) begin
                    n_pc = w.target;
                end
            end
            default: begin
                n_pc = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/slw_datapath.sv =====
module slw_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  slw_pkg::t_ctrl                 i_ctrl,
    input  logic [slw_pkg::ROW_BITS-1:0]   i_rd_data,
    input  logic                           i_stall,
    output logic [slw_pkg::ROW_W-1:0]      o_rd_row,
    output logic                           o_walk_done,
    output logic                           o_last_loaded,
    output logic                           o_valid,
    output logic [10:0]                    o_tile_number,
    output logic [1:0]                     o_palette_line,
    output logic                           o_priority_res,
    output logic                           o_flip_vertical,
    output logic                           o_flip_horizontal,
    output logic [9:0]                     o_x_position,
    output logic [10:0]                    o_y_position,
    output logic [6:0]                     o_sprite_number,
    output logic                           o_last_tile,
    output logic                           o_end_of_list
);
    import slw_pkg::*;

    // walk state
    logic [ROW_W-1:0] r_current;
    logic [6:0]       r_visited;
    logic             r_done;

    // decoded sprite
    logic [9:0]       r_ypos;
    logic [8:0]       r_xpos;
    logic [1:0]       r_wmax;
    logic [1:0]       r_hmax;
    logic             r_prio;
    logic [1:0]       r_pal;
    logic             r_vflip;
    logic             r_hflip;
    logic [10:0]      r_base;
    logic [ROW_W-1:0] r_link;
    logic             r_ends;

    // tile counters
    logic [1:0]       r_col;
    logic [1:0]       r_row;
    logic [3:0]       r_tile;

    // output register
    logic             r_ovalid;
    logic [10:0]      r_tile_number;
    logic [1:0]       r_palette_line;
    logic             r_priority_res;
    logic             r_flip_vertical;
    logic             r_flip_horizontal;
    logic [9:0]       r_x_position;
    logic [10:0]      r_y_position;
    logic [6:0]       r_sprite_number;
    logic             r_last_tile;
    logic             r_end_of_list;

    logic [7:0]       b0, b1, b2, b3, b4, b5, b6, b7;
    logic [7:0]       visited_inc;
    logic [ROW_W-1:0] link_dec;
    logic             ends_dec;
    logic             load;
    logic             tile_last;

    always_comb begin
        b0 = i_rd_data[7:0];
        b1 = i_rd_data[15:8];
        b2 = i_rd_data[23:16];
        b3 = i_rd_data[31:24];
        b4 = i_rd_data[39:32];
        b5 = i_rd_data[47:40];
        b6 = i_rd_data[55:48];
        b7 = i_rd_data[63:56];
        link_dec    = b3[ROW_W-1:0];
        visited_inc = {1'b0, r_visited} + 8'd1;
        ends_dec    = (link_dec == '0)
                   || ({1'b0, link_dec} >= (ROW_W + 1)'(SPRITE_ENTRIES))
                   || (visited_inc >= 8'(SPRITE_ENTRIES));
        tile_last = (r_col == r_wmax) && (r_row == r_hmax);
        load      = i_ctrl.emit && (!r_ovalid || !i_stall);
    end

    assign o_rd_row      = r_current;
    assign o_walk_done   = r_done;
    assign o_last_loaded = load && tile_last;

    // walk state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current <= '0;
            r_visited <= '0;
            r_done    <= 1'b0;
        end else if (i_ctrl.restart) begin
            r_current <= '0;
            r_visited <= '0;
            r_done    <= 1'b0;
        end else if (i_ctrl.fin) begin
            r_visited <= visited_inc[6:0];
            if (r_ends) begin
                r_done <= 1'b1;
            end else begin
                r_current <= r_link;
            end
        end
    end

    // sprite decode
    always_ff @(posedge i_clk) begin
        if (i_ctrl.dec) begin
            r_ypos  <= {b0[1:0], b1};
            r_xpos  <= {b6[0], b7};
            r_wmax  <= b2[3:2];
            r_hmax  <= b2[1:0];
            r_prio  <= b4[7];
            r_pal   <= b4[6:5];
            r_vflip <= b4[4];
            r_hflip <= b4[3];
            r_base  <= {b4[2:0], b5};
            r_link  <= link_dec;
            r_ends  <= ends_dec;
        end
    end

    // column-major tile walk
    always_ff @(posedge i_clk) begin
        if (i_ctrl.dec) begin
            r_col  <= '0;
            r_row  <= '0;
            r_tile <= '0;
        end else if (load) begin
            r_tile <= r_tile + 1'b1;
            if (r_row == r_hmax) begin
                r_row <= '0;
                r_col <= r_col + 1'b1;
            end else begin
                r_row <= r_row + 1'b1;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tile_number     <= r_base + {7'd0, r_tile};
            r_palette_line    <= r_pal;
            r_priority_res    <= r_prio;
            r_flip_vertical   <= r_vflip;
            r_flip_horizontal <= r_hflip;
            r_x_position      <= {1'b0, r_xpos} + {5'd0, r_col, 3'd0};
            r_y_position      <= {1'b0, r_ypos} + {6'd0, r_row, 3'd0};
            r_sprite_number   <= r_current;
            r_last_tile       <= tile_last;
            r_end_of_list     <= r_ends;
        end
    end

    // result ports straight from the output register
    assign o_valid           = r_ovalid;
    assign o_tile_number     = r_tile_number;
    assign o_palette_line    = r_palette_line;
    assign o_priority_res    = r_priority_res;
    assign o_flip_vertical   = r_flip_vertical;
    assign o_flip_horizontal = r_flip_horizontal;
    assign o_x_position      = r_x_position;
    assign o_y_position      = r_y_position;
    assign o_sprite_number   = r_sprite_number;
    assign o_last_tile       = r_last_tile;
    assign o_end_of_list     = r_end_of_list;

endmodule

// ===== rtl/sprite_list_tile_walker.sv =====
// Sprite list walker over an 80-entry, 8-byte-per-sprite attribute table held as 80 rows
// of 64 bits. A write request stores one byte, a restart request points the walk at
// sprite 0, and a step request reads the current sprite row and gives one result per
// 8x8 tile in column-major order before following the link. A step runs the read, decode,
// emit and finish steps in order; the output register takes one tile per cycle while the
// output side does not stall. Each tile of a step waits while an earlier result still sits
// in the output register and the output side stalls. After reset the table is cleared one
// row a cycle, so no request is taken until every row is cleared.
module sprite_list_tile_walker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [9:0]  i_byte_address,
    input  logic [7:0]  i_byte_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_tile_number,
    output logic [1:0]  o_palette_line,
    output logic        o_priority_res,
    output logic        o_flip_vertical,
    output logic        o_flip_horizontal,
    output logic [9:0]  o_x_position,
    output logic [10:0] o_y_position,
    output logic [6:0]  o_sprite_number,
    output logic        o_last_tile,
    output logic        o_end_of_list
);
    import slw_pkg::*;

    t_ctrl               ctrl;
    t_status             status;
    logic [ROW_BITS-1:0] rd_data;
    logic [ROW_W-1:0]    rd_row;
    logic                clr_last;
    logic                walk_done;
    logic                last_loaded;

    assign status = '{walk_done: walk_done, last_loaded: last_loaded, clr_last: clr_last};

    // program sequencer
    slw_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .i_wr_row (i_byte_address[9:3]),
        .i_status (status),
        .o_stall  (o_stall),
        .o_ctrl   (ctrl)
    );

    // attribute table
    slw_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_wr_row   (i_byte_address[9:3]),
        .i_wr_lane  (i_byte_address[2:0]),
        .i_wr_byte  (i_byte_value),
        .i_rd_row   (rd_row),
        .o_rd_data  (rd_data),
        .o_clr_last (clr_last)
    );

    // decode, tile walk and output register
    slw_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (ctrl),
        .i_rd_data         (rd_data),
        .i_stall           (i_stall),
        .o_rd_row          (rd_row),
        .o_walk_done       (walk_done),
        .o_last_loaded     (last_loaded),
        .o_valid           (o_valid),
        .o_tile_number     (o_tile_number),
        .o_palette_line    (o_palette_line),
        .o_priority_res    (o_priority_res),
        .o_flip_vertical   (o_flip_vertical),
        .o_flip_horizontal (o_flip_horizontal),
        .o_x_position      (o_x_position),
        .o_y_position      (o_y_position),
        .o_sprite_number   (o_sprite_number),
        .o_last_tile       (o_last_tile),
        .o_end_of_list     (o_end_of_list)
    );

endmodule
